@@ sv/frame_rotate_quarter_turns_assert.svh @@
// ----------------------------------------------------------------------------
// frame_rotate_quarter_turns assertion macros
// shared helpers for concurrent checks on clk, with or without rst_n as reset
// ----------------------------------------------------------------------------
`ifndef FRAME_ROTATE_QUARTER_TURNS_ASSERT_SVH
`define FRAME_ROTATE_QUARTER_TURNS_ASSERT_SVH

// check a property on every rising edge of clk, quiet while rst_n is low
`define FRQT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge of clk, reset included
`define FRQT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/frot_pkg.sv @@
// ----------------------------------------------------------------------------
// frot_pkg
// types, constants and helpers shared by the frame rotator modules
// ----------------------------------------------------------------------------
`default_nettype none

package frot_pkg;

    // field widths
    localparam int DIM_BITS       = 7;
    localparam int DEG_BITS       = 9;
    localparam int PIX_W          = 32;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 9;
    localparam int OUT_FIELD_BITS = PIX_W + 2 * DIM_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    // largest dimension a register can express
    localparam int DIM_MAX_CODE = (1 << DIM_BITS) - 1;

    // parameter defaults
    localparam int MAX_DIM_DEF    = 64;
    localparam int PIXEL_BITS_DEF = 32;

    // register reset values
    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(64);

    // angle constants
    localparam int DEG_FULL    = 360;
    localparam int DEG_QUARTER = 90;

    // item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_DEGREES = 2'd2,
        CFG_LEFT    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic cfg_we;
        logic load_en;
        logic fetch_en;
    } cmd_t;

    // force a dimension into 1..cap
    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] cap
    );
        logic [DIM_BITS-1:0] r;
        if (v == '0)
            r = DIM_BITS'(1);
        else if (v > cap)
            r = cap;
        else
            r = v;
        return r;
    endfunction

    // clockwise quarter turns from angle and direction
    function automatic logic [1:0] quarter_turns(
        input logic [DEG_BITS-1:0] deg,
        input logic                left
    );
        logic [DEG_BITS-1:0] d;
        logic [1:0]          q;
        d = (deg >= DEG_BITS'(DEG_FULL)) ? deg - DEG_BITS'(DEG_FULL) : deg;
        if (left)
            d = DEG_BITS'(DEG_FULL) - d;
        if (d >= DEG_BITS'(DEG_FULL))
            q = 2'd0;
        else if (d >= DEG_BITS'(3 * DEG_QUARTER))
            q = 2'd3;
        else if (d >= DEG_BITS'(2 * DEG_QUARTER))
            q = 2'd2;
        else if (d >= DEG_BITS'(DEG_QUARTER))
            q = 2'd1;
        else
            q = 2'd0;
        return q;
    endfunction

endpackage

`default_nettype wire

@@ sv/frot_ctrl.sv @@
// ----------------------------------------------------------------------------
// frot_ctrl
// handshake controller: tracks the output register and issues commands
// ----------------------------------------------------------------------------
`default_nettype none

module frot_ctrl
    import frot_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_valid,
    input  wire logic s_op,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    output cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        take;

    // output register free, or being emptied this cycle
    always_comb
    begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_EMPTY:
            begin
                s_ready = 1'b1;
            end
            ST_FULL:
            begin
                m_valid = 1'b1;
                s_ready = m_ready;
            end
            default:
            begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign take      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmd.cfg_we   = cfg_valid;
        cmd.load_en  = take && (s_op == OP_LOAD);
        cmd.fetch_en = take && (s_op == OP_FETCH);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.fetch_en)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (m_ready && !cmd.fetch_en)
                    state_next = ST_EMPTY;
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ sv/frot_datapath.sv @@
// ----------------------------------------------------------------------------
// frot_datapath
// config registers, frame store, load and fetch counters, output register
// ----------------------------------------------------------------------------
`default_nettype none

module frot_datapath
    import frot_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic [PIX_W-1:0]         pixel_in,
    output logic      [PIX_W-1:0]         pixel_out,
    output logic      [DIM_BITS-1:0]      out_width,
    output logic      [DIM_BITS-1:0]      out_height,
    output logic                          end_of_row,
    output logic                          end_of_frame
);

    localparam int DIM_CAP    = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
    localparam int POS_W      = $clog2(DIM_CAP);
    localparam int DEPTH      = DIM_CAP * DIM_CAP;
    localparam int AW         = $clog2(DEPTH);
    localparam int SIZE_W     = AW + 1;
    localparam int STORE_BITS = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
    localparam logic [DIM_BITS-1:0] CAP_CODE = DIM_BITS'(DIM_CAP);

    // configuration
    logic [DIM_BITS-1:0] frame_width_reg;
    logic [DIM_BITS-1:0] frame_height_reg;
    logic [DEG_BITS-1:0] turn_degrees_reg;
    logic                turn_left_reg;

    // counters
    logic [AW-1:0]    load_ptr_reg,  load_ptr_next;
    logic [POS_W-1:0] out_row_reg,   out_row_next;
    logic [POS_W-1:0] out_col_reg,   out_col_next;

    // output payload
    logic [STORE_BITS-1:0] pix_reg;
    logic [DIM_BITS-1:0]   ow_reg, oh_reg;
    logic                  eor_reg, eof_reg;

    logic [STORE_BITS-1:0] frame_mem [DEPTH];

    logic [DIM_BITS-1:0] w, h, ow, oh;
    logic [1:0]          q;
    logic [SIZE_W-1:0]   frame_size;
    logic [AW-1:0]       lp_eff;
    logic [SIZE_W-1:0]   lp_inc;
    logic [POS_W-1:0]    row_eff, col_eff;
    logic [DIM_BITS-1:0] row_ext, col_ext;
    logic [POS_W-1:0]    src_row, src_col;
    logic [AW-1:0]       rd_addr;
    logic                col_last, row_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
            turn_degrees_reg <= '0;
            turn_left_reg    <= 1'b0;
        end
        else if (cmd.cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WIDTH:   frame_width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_HEIGHT:  frame_height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_DEGREES: turn_degrees_reg <= cfg_data[DEG_BITS-1:0];
                CFG_LEFT:    turn_left_reg    <= cfg_data[0];
            endcase
        end
    end

    assign w  = clamp_dim(frame_width_reg, CAP_CODE);
    assign h  = clamp_dim(frame_height_reg, CAP_CODE);
    assign q  = quarter_turns(turn_degrees_reg, turn_left_reg);
    assign ow = q[0] ? h : w;
    assign oh = q[0] ? w : h;

    // load side: pointer restarts if the frame shrank under it
    assign frame_size    = SIZE_W'(w) * SIZE_W'(h);
    assign lp_eff        = (SIZE_W'(load_ptr_reg) >= frame_size) ? '0 : load_ptr_reg;
    assign lp_inc        = SIZE_W'(lp_eff) + SIZE_W'(1);
    assign load_ptr_next = (lp_inc >= frame_size) ? '0 : lp_inc[AW-1:0];

    // fetch side: output raster position mapped back to source
    assign row_eff = (DIM_BITS'(out_row_reg) >= oh) ? '0 : out_row_reg;
    assign col_eff = (DIM_BITS'(out_col_reg) >= ow) ? '0 : out_col_reg;
    assign row_ext = DIM_BITS'(row_eff);
    assign col_ext = DIM_BITS'(col_eff);

    always_comb
    begin
        unique case (q)
            2'd1:
            begin
                src_row = POS_W'(h - DIM_BITS'(1) - col_ext);
                src_col = row_eff;
            end
            2'd2:
            begin
                src_row = POS_W'(h - DIM_BITS'(1) - row_ext);
                src_col = POS_W'(w - DIM_BITS'(1) - col_ext);
            end
            2'd3:
            begin
                src_row = col_eff;
                src_col = POS_W'(w - DIM_BITS'(1) - row_ext);
            end
            default:
            begin
                src_row = row_eff;
                src_col = col_eff;
            end
        endcase
    end

    assign rd_addr  = AW'(src_row) * AW'(w) + AW'(src_col);
    assign col_last = (col_ext == ow - DIM_BITS'(1));
    assign row_last = (row_ext == oh - DIM_BITS'(1));

    always_comb
    begin
        out_col_next = col_last ? '0 : POS_W'(col_ext + DIM_BITS'(1));
        if (!col_last)
            out_row_next = row_eff;
        else if (row_last)
            out_row_next = '0;
        else
            out_row_next = POS_W'(row_ext + DIM_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
        end
        else
        begin
            if (cmd.load_en)
                load_ptr_reg <= load_ptr_next;
            if (cmd.fetch_en)
            begin
                out_row_reg <= out_row_next;
                out_col_reg <= out_col_next;
            end
        end
    end

    // single-port frame store
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
            frame_mem[lp_eff] <= pixel_in[STORE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_en)
        begin
            pix_reg <= frame_mem[rd_addr];
            ow_reg  <= ow;
            oh_reg  <= oh;
            eor_reg <= col_last;
            eof_reg <= col_last && row_last;
        end
    end

    assign pixel_out    = PIX_W'(pix_reg);
    assign out_width    = ow_reg;
    assign out_height   = oh_reg;
    assign end_of_row   = eor_reg;
    assign end_of_frame = eof_reg;

endmodule

`default_nettype wire

@@ sv/frame_rotate_quarter_turns.sv @@
// ----------------------------------------------------------------------------
// frame_rotate_quarter_turns
// frame store that reads back its contents turned by a multiple of 90 degrees
// ----------------------------------------------------------------------------
// Load requests (tuser low) write source pixels in row-major order into a
// single-port frame store of MAX_DIM x MAX_DIM entries; the write pointer
// wraps after width x height pixels. Fetch requests (tuser high) read the
// next pixel of the rotated frame in output raster order and return it
// through an output register, with the rotated dimensions, an
// end-of-row flag on tuser and an end-of-frame mark on tlast. The block takes
// one request per cycle, loads and fetches mixed freely: the single store
// port serves either one write or one read each cycle, and the source
// address costs a row-by-width multiply and add ahead of that port. While a result
// waits in the output register a new request is taken only in the cycle it
// drains. There is no clearing pass after reset; reading a pixel that was
// never loaded returns an undefined value. Configuration writes are taken
// every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rotate_quarter_turns
    import frot_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [PIX_W-1:0]          s_axis_tdata,   // pixel_in
    input  wire logic                      s_axis_tuser,   // operation
    // result stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [OUT_TDATA_BITS-1:0] m_axis_tdata,   // pixel_out, out_width,
                                                           // out_height, zero pad
    output logic                           m_axis_tuser,   // end_of_row
    output logic                           m_axis_tlast,   // end_of_frame
    // configuration writes
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cmd_t                cmd;
    logic [PIX_W-1:0]    pixel_out;
    logic [DIM_BITS-1:0] out_width;
    logic [DIM_BITS-1:0] out_height;

    // handshakes and output register occupancy
    frot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_op      (s_axis_tuser),
        .s_ready   (s_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // store, counters and address mapping
    frot_datapath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (s_axis_tdata),
        .pixel_out    (pixel_out),
        .out_width    (out_width),
        .out_height   (out_height),
        .end_of_row   (m_axis_tuser),
        .end_of_frame (m_axis_tlast)
    );

    // pixel in the low bits, then the rotated dimensions
    assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, out_height, out_width, pixel_out};

endmodule

`default_nettype wire

@@ sv/frot_checker.sv @@
// ----------------------------------------------------------------------------
// frot_checker
// port-level checks on the frame rotator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rotate_quarter_turns_assert.svh"

module frot_checker
    import frot_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic                      s_axis_tuser,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input wire logic                      m_axis_tuser,
    input wire logic                      m_axis_tlast
);

    logic fetch_acc;
    logic load_acc;
    logic load_idle;
    logic out_stall;
    logic frame_end;
    logic row_end_ok;

    assign fetch_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FETCH);
    assign load_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD);
    assign load_idle  = load_acc && !m_axis_tvalid;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign frame_end  = m_axis_tvalid && m_axis_tlast;
    // row end flagged and a nonzero output width
    assign row_end_ok = m_axis_tuser && (m_axis_tdata[PIX_W +: DIM_BITS] != '0);

    // a stalled result stays offered
    `FRQT_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid, "result dropped while stalled")

    // every fetch yields a result in the next cycle
    `FRQT_ASSERT(a_fetch_result, fetch_acc |=> m_axis_tvalid, "fetch gave no result")

    // a load taken while no result is offered leaves the output empty
    `FRQT_ASSERT(a_load_silent, load_idle |=> !m_axis_tvalid, "load gave a result")

    // the last pixel of a frame also closes its row and carries a nonzero output width
    `FRQT_ASSERT(a_frame_row, frame_end |-> row_end_ok, "frame end off a row end")

endmodule

bind frame_rotate_quarter_turns frot_checker u_frot_checker (.*);

`default_nettype wire

@@ verif/frame_rotate_quarter_turns_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_rotate_quarter_turns_tb
// self-checking bench for the quarter-turn frame rotator
// ----------------------------------------------------------------------------
// Load and fetch requests are queued up one setting at a time and pushed into
// the block by a clocked driver with random gaps. A clocked monitor takes the
// rotated pixels with random stalls and checks each one against a behavioural
// copy of the rotator that runs on every accepted request. A planning copy of
// the same rotator tracks which store entries hold data, so a fetch is only
// queued once its source pixel has been loaded. Settings change between
// batches only, once every result is back, and include clamped dimensions,
// odd angles, angles past a full turn and left turns. One long receiver
// hold-off makes the block back up and stall its input.
// ----------------------------------------------------------------------------

module frame_rotate_quarter_turns_tb;

    import frot_pkg::*;

    localparam int MAX_DIM       = MAX_DIM_DEF;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int MAX_PAUSE     = 15;
    localparam int HOLD_CYCLES   = 200;
    // result register plus a little margin before a settings change
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int END_WAIT      = 2000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int TIMEOUT_NS    = 5_000_000;

    // which copy of the rotator state a call works on
    localparam int PLAN  = 0;   // advanced when a request is queued
    localparam int CHECK = 1;   // advanced when a request is accepted

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pix;
    } request_t;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic                row_end;
        logic                frame_end;
    } rot_pixel_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request stream
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [PIX_W-1:0]          s_axis_tdata  = '0;     // pixel_in
    logic                      s_axis_tuser  = OP_LOAD; // operation

    // result stream
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // pixel_out, out_width, out_height, pad
    logic                      m_axis_tuser;   // end_of_row
    logic                      m_axis_tlast;   // end_of_frame

    // register writes
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // rotator copies: registers are shared since they only change while idle
    logic [DIM_BITS-1:0] reg_width   = DIM_RESET;
    logic [DIM_BITS-1:0] reg_height  = DIM_RESET;
    logic [DEG_BITS-1:0] reg_degrees = '0;
    logic                reg_left    = 1'b0;
    logic [PIX_W-1:0]    pix_mem    [0:1][0:STORE_DEPTH-1];
    bit                  pix_loaded [0:STORE_DEPTH-1];
    int unsigned         load_ptr   [0:1] = '{0, 0};
    int unsigned         out_r      [0:1] = '{0, 0};
    int unsigned         out_c      [0:1] = '{0, 0};

    request_t    pending_q [$];   // requests waiting for the driver
    rot_pixel_t  rotated_q [$];   // rotated pixels still to come back

    int unsigned items_queued   = 0;
    int unsigned accepted_count = 0;
    int unsigned loads_sent     = 0;
    int unsigned fetches_sent   = 0;
    int unsigned pixels_checked = 0;
    int unsigned settings_used  = 0;
    int unsigned fail_count     = 0;
    int unsigned tx_pause       = 0;
    int unsigned rx_pause       = 0;
    bit          steady         = 1'b0;  // no idling on either side
    bit          hold_request   = 1'b0;
    logic        rx_hold        = 1'b0;

    frame_rotate_quarter_turns #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS_DEF)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // behavioural rotator
    // ------------------------------------------------------------------------

    // zero acts as one, anything past the store edge acts as the edge
    function automatic int unsigned eff_dim(input logic [DIM_BITS-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // clockwise quarter turns; a left turn counts back from a full circle
    function automatic int unsigned quarter_count();
        int unsigned d;
        d = int'(reg_degrees) % DEG_FULL;
        if (reg_left)
            d = DEG_FULL - d;
        return (d / DEG_QUARTER) % 4;
    endfunction

    // store address behind the next output pixel, with the output size
    task automatic locate_source(input int k, output int unsigned addr,
                                 output int unsigned ow, output int unsigned oh);
        int unsigned w, h, q, r, c, sr, sc;
        w  = eff_dim(reg_width);
        h  = eff_dim(reg_height);
        q  = quarter_count();
        ow = (q % 2 == 1) ? h : w;
        oh = (q % 2 == 1) ? w : h;
        // a smaller frame after a settings change restarts the scan
        if (out_r[k] >= oh)
            out_r[k] = 0;
        if (out_c[k] >= ow)
            out_c[k] = 0;
        r = out_r[k];
        c = out_c[k];
        case (q)
            1:       begin sr = h - 1 - c; sc = r;         end
            2:       begin sr = h - 1 - r; sc = w - 1 - c; end
            3:       begin sr = c;         sc = w - 1 - r; end
            default: begin sr = r;         sc = c;         end
        endcase
        addr = (sr * w + sc) % STORE_DEPTH;
    endtask

    task automatic rotate_step(input int k, input logic op, input logic [PIX_W-1:0] pix,
                               output bit emits, output rot_pixel_t res);
        int unsigned area, addr, ow, oh;
        emits = 1'b0;
        res   = '0;
        if (op == OP_LOAD)
        begin
            area = eff_dim(reg_width) * eff_dim(reg_height);
            if (load_ptr[k] >= area)
                load_ptr[k] = 0;
            pix_mem[k][load_ptr[k]] = pix;
            if (k == PLAN)
                pix_loaded[load_ptr[k]] = 1'b1;
            load_ptr[k]++;
            if (load_ptr[k] >= area)
                load_ptr[k] = 0;
        end
        else
        begin
            locate_source(k, addr, ow, oh);
            res.pixel     = pix_mem[k][addr];
            res.width     = DIM_BITS'(ow);
            res.height    = DIM_BITS'(oh);
            res.row_end   = (out_c[k] == ow - 1);
            res.frame_end = (out_c[k] == ow - 1) && (out_r[k] == oh - 1);
            emits         = 1'b1;
            out_c[k]++;
            if (out_c[k] >= ow)
            begin
                out_c[k] = 0;
                out_r[k]++;
                if (out_r[k] >= oh)
                    out_r[k] = 0;
            end
        end
    endtask

    // cycles to wait after a request; runs of zero keep the block busy
    function automatic int unsigned draw_pause();
        if (steady || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, MAX_PAUSE);
    endfunction

    // ------------------------------------------------------------------------
    // request driver: one request in flight, random gap after each
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        bit         emits;
        rot_pixel_t res;
        request_t   rq;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_pause = 0;
        end
        else
        begin
            // accepted request: run it through the checking copy
            if (s_axis_tvalid && s_axis_tready)
            begin
                rotate_step(CHECK, s_axis_tuser, s_axis_tdata, emits, res);
                if (emits)
                begin
                    rotated_q.push_back(res);
                    fetches_sent++;
                end
                else
                    loads_sent++;
                accepted_count++;
            end
            // slot free: either sit out the gap or offer the next request
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_pause > 0)
                begin
                    tx_pause--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    rq = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= rq.op;
                    s_axis_tdata  <= rq.pix;
                    tx_pause = draw_pause();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares against the oldest expected pixel
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        rot_pixel_t got;
        rot_pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_pause = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pixel     = m_axis_tdata[PIX_W-1:0];
                got.width     = m_axis_tdata[PIX_W +: DIM_BITS];
                got.height    = m_axis_tdata[PIX_W + DIM_BITS +: DIM_BITS];
                got.row_end   = m_axis_tuser;
                got.frame_end = m_axis_tlast;
                if (rotated_q.size() == 0)
                begin
                    $error("unexpected result: pixel_out %0h", got.pixel);
                    fail_count++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    compare_field("pixel_out", want.pixel, got.pixel);
                    compare_field("out_width", PIX_W'(want.width), PIX_W'(got.width));
                    compare_field("out_height", PIX_W'(want.height), PIX_W'(got.height));
                    compare_field("end_of_row", PIX_W'(want.row_end), PIX_W'(got.row_end));
                    compare_field("end_of_frame", PIX_W'(want.frame_end),
                                  PIX_W'(got.frame_end));
                    pixels_checked++;
                end
                rx_pause = draw_pause();
            end
            if (rx_hold)
                m_axis_tready <= 1'b0;
            else if (rx_pause > 0)
            begin
                rx_pause--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // long receiver hold-off so the result register fills and input backs up
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // called just after a rising edge; leaves cfg_valid high on return
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WIDTH:   reg_width   = val[DIM_BITS-1:0];
            CFG_HEIGHT:  reg_height  = val[DIM_BITS-1:0];
            CFG_DEGREES: reg_degrees = val[DEG_BITS-1:0];
            CFG_LEFT:    reg_left    = val[0];
            default:     ;
        endcase
    endtask

    task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] w,
                                 input logic [CFG_DATA_BITS-1:0] h,
                                 input logic [CFG_DATA_BITS-1:0] deg,
                                 input logic [CFG_DATA_BITS-1:0] left);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_DEGREES, deg);
        write_reg(CFG_LEFT, left);
        cfg_valid <= 1'b0;
        settings_used++;
        steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic add_load(input logic [PIX_W-1:0] pix);
        request_t   rq;
        bit         emits;
        rot_pixel_t res;
        rq.op  = OP_LOAD;
        rq.pix = pix;
        pending_q.push_back(rq);
        rotate_step(PLAN, OP_LOAD, pix, emits, res);
        items_queued++;
    endtask

    // loads random pixels first if the source entry was never written
    task automatic add_fetch();
        request_t    rq;
        bit          emits;
        rot_pixel_t  res;
        int unsigned addr, ow, oh;
        locate_source(PLAN, addr, ow, oh);
        while (!pix_loaded[addr])
            add_load($urandom);
        rq.op  = OP_FETCH;
        rq.pix = $urandom;
        pending_q.push_back(rq);
        rotate_step(PLAN, OP_FETCH, rq.pix, emits, res);
        items_queued++;
    endtask

    // every request accepted and every pixel back, then let the block go quiet
    task automatic settle();
        while (accepted_count != items_queued || rotated_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned              n, pct, phase, area, i;
        logic [CFG_DATA_BITS-1:0] w, h, deg, wide, narrow;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pixel extremes, every turn count, clamped width,
        // odd angle to the left, angle beyond a full turn
        apply_setting(9'd3, 9'd2, 9'd90, 9'd0);
        add_load(32'h8000_0000);
        add_load(32'h7fff_ffff);
        add_load(32'h0000_0000);
        add_load(32'hffff_ffff);
        add_load(32'h5555_5555);
        add_load(32'haaaa_aaaa);
        repeat (6) add_fetch();
        settle();
        apply_setting(9'd0, 9'd2, 9'd45, 9'd1);
        repeat (2) add_fetch();
        settle();
        apply_setting(9'd2, 9'd3, 9'd180, 9'd0);
        repeat (3) add_fetch();
        settle();
        apply_setting(9'd2, 9'd3, 9'd0, 9'd1);
        repeat (3) add_fetch();
        settle();
        apply_setting(9'd2, 9'd3, 9'd450, 9'd1);
        repeat (3) add_fetch();
        settle();

        // random batches, one setting each; the hold-off batch always runs
        phase = 0;
        while (items_queued < RANDOM_ITEMS + 23 || phase <= 2)
        begin
            // mostly small frames, now and then one long edge (clamped too)
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       wide = CFG_DATA_BITS'(MAX_DIM);
                    1:       wide = CFG_DATA_BITS'(DIM_MAX_CODE);
                    default: wide = CFG_DATA_BITS'($urandom_range(9, DIM_MAX_CODE));
                endcase
                narrow = CFG_DATA_BITS'($urandom_range(0, 2));
                w = $urandom_range(0, 1) ? wide : narrow;
                h = (w == wide) ? narrow : wide;
            end
            else
            begin
                w = CFG_DATA_BITS'($urandom_range(0, 8));
                h = CFG_DATA_BITS'($urandom_range(0, 8));
            end
            case ($urandom_range(0, 5))
                0, 1, 2, 3: deg = CFG_DATA_BITS'($urandom_range(0, 3) * DEG_QUARTER);
                4:          deg = CFG_DATA_BITS'(DEG_FULL + $urandom_range(0, 1) * DEG_QUARTER);
                default:    deg = CFG_DATA_BITS'($urandom_range(0, (1 << DEG_BITS) - 1));
            endcase
            apply_setting(w, h, deg, CFG_DATA_BITS'($urandom_range(0, 1)));
            area = eff_dim(reg_width) * eff_dim(reg_height);

            if (phase == 2)
            begin
                // fetch-heavy batch during the receiver hold-off
                hold_request = 1'b1;
                steady = 1'b1;
                for (i = 0; i < 60; i++)
                    if ($urandom_range(0, 9) < 8)
                        add_fetch();
                    else
                        add_load($urandom);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                // whole frames: load one, read it back rotated
                repeat ($urandom_range(1, 2))
                begin
                    repeat (area) add_load($urandom);
                    repeat (area) add_fetch();
                end
            end
            else
            begin
                n   = $urandom_range(20, 60);
                pct = $urandom_range(30, 90);
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 99) < pct)
                        add_fetch();
                    else
                        add_load($urandom);
            end
            settle();
            phase++;
        end

        // final drain, bounded so a missing pixel counts as a failure
        for (i = 0; i < END_WAIT && (accepted_count != items_queued || rotated_q.size() != 0);
             i++)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (rotated_q.size() != 0)
        begin
            $error("%0d rotated pixels never arrived", rotated_q.size());
            fail_count += rotated_q.size();
        end

        $display("frame_rotate_quarter_turns_tb: %0d loads and %0d fetches over %0d settings",
                 loads_sent, fetches_sent, settings_used);
        $display("frame_rotate_quarter_turns_tb: %0d rotated pixels compared, %0d mismatches",
                 pixels_checked, fail_count);
        if (fail_count == 0)
            $display("frame_rotate_quarter_turns_tb: done, clean");
        else
            $display("frame_rotate_quarter_turns_tb: done, errors");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("frame_rotate_quarter_turns_tb: done, errors");
        $finish;
    end

endmodule
